// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the heap priority queue block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge once reset is released.
`define BHPQ_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define BHPQ_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// File: hdl/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// bhpq_pkg
// Shared types, codes and helpers of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  localparam int DEPTH     = 256;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int PAY_W     = 16;
  localparam int PRIO_W    = 16;
  localparam int ENTRY_W   = PAY_W + PRIO_W;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 3;
  localparam int CAP_W     = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE  = 3'd0,
    CMD_DEQUEUE  = 3'd1,
    CMD_INC_KEY  = 3'd2,
    CMD_DEC_KEY  = 3'd3,
    CMD_CLEAR    = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_BAD_SLOT  = 3'd3,
    ST_UNCHANGED = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DQ_ROOT,
    S_DQ_LAST,
    S_KEY_RD,
    S_UP_RD,
    S_UP_CMP,
    S_DN_L,
    S_DN_R,
    S_DN_PICK
  } state_t;

  function automatic logic signed [PRIO_W-1:0] prio_of(input entry_t e);
    prio_of = $signed(e[PRIO_W-1:0]);
  endfunction

  function automatic entry_t make_entry(input logic [PAY_W-1:0] pay,
                                        input logic [PRIO_W-1:0] pri);
    make_entry = {pay, pri};
  endfunction

endpackage

`default_nettype wire

// File: hdl/bhpq_ram.sv
// ----------------------------------------------------------------------------
// bhpq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/binary_max_heap_priority_queue.sv
// ----------------------------------------------------------------------------
// binary_max_heap_priority_queue
// Array-based binary max-heap of (payload, priority) entries held in one RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Ports
//   -------   -------------------   ---------------------------------------
//   request   start & !busy         in_command, in_payload, in_priority_req,
//                                   in_slot
//   result    out_valid (1 cycle)   out_status, out_payload, out_priority,
//                                   out_occupancy, out_is_empty
//   config    cfg_valid & cfg_ready cfg_capacity
//
// One request is worked on at a time; busy is high from the cycle after a
// request that needs the heap RAM is taken until its result strobe. Every
// level of a sift goes through the single read port of the heap RAM: sift up
// passes through S_UP_RD and S_UP_CMP per level, sift down through S_DN_L,
// S_DN_R and, when a right child exists, S_DN_PICK. A sift moves at most 7
// levels. Full, empty and bad-slot rejections and clear are answered in S_IDLE.
// Reset (synchronous, active low) empties the queue and sets capacity to 256;
// the RAM is not cleared since only occupied slots are ever read. The result
// is shown for exactly one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_max_heap_priority_queue (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // request channel
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [bhpq_pkg::CMD_W-1:0]            in_command,
  input  wire logic [bhpq_pkg::PAY_W-1:0]            in_payload,
  input  wire logic signed [bhpq_pkg::PRIO_W-1:0]    in_priority_req,
  input  wire logic [bhpq_pkg::ADDR_W-1:0]           in_slot,
  // result channel
  output logic                                       out_valid,
  output logic [bhpq_pkg::STATUS_W-1:0]              out_status,
  output logic [bhpq_pkg::PAY_W-1:0]                 out_payload,
  output logic signed [bhpq_pkg::PRIO_W-1:0]         out_priority,
  output logic [bhpq_pkg::CNT_W-1:0]                 out_occupancy,
  output logic                                       out_is_empty,
  // configuration channel
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [bhpq_pkg::CAP_W-1:0]            cfg_capacity
);

`include "assert_macros.svh"

  // Control state.
  bhpq_pkg::state_t                 state_r, state_nxt;
  logic [bhpq_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [bhpq_pkg::CAP_W-1:0]       capacity_r;
  logic                             out_valid_r, out_valid_nxt;

  // Working registers of the current request.
  bhpq_pkg::entry_t                 hold_r, hold_nxt;     // entry being sifted
  bhpq_pkg::entry_t                 child_r, child_nxt;   // left child during sift down
  logic [bhpq_pkg::ADDR_W-1:0]      pos_r, pos_nxt;       // hole position
  logic [bhpq_pkg::ADDR_W-1:0]      caddr_r, caddr_nxt;   // parent or left child address
  logic signed [bhpq_pkg::PRIO_W-1:0] req_r, req_nxt;
  logic                             key_up_r, key_up_nxt;
  logic [bhpq_pkg::STATUS_W-1:0]    status_r, status_nxt;
  logic [bhpq_pkg::PAY_W-1:0]       opay_r, opay_nxt;
  logic [bhpq_pkg::PRIO_W-1:0]      opri_r, opri_nxt;

  // RAM port signals.
  logic                             mem_we;
  logic [bhpq_pkg::ADDR_W-1:0]      mem_waddr;
  bhpq_pkg::entry_t                 mem_wdata;
  logic [bhpq_pkg::ADDR_W-1:0]      mem_raddr;
  bhpq_pkg::entry_t                 mem_rdata;

  // Effective capacity is never above the store depth.
  logic [bhpq_pkg::CNT_W-1:0]       limit;
  // Sift down helpers.
  logic [bhpq_pkg::CNT_W-1:0]       left_idx;
  logic [bhpq_pkg::CNT_W-1:0]       right_idx;
  bhpq_pkg::entry_t                 cand;
  logic [bhpq_pkg::ADDR_W-1:0]      cand_addr;
  bhpq_pkg::entry_t                 key_entry;
  logic                             key_ok;

  bhpq_ram #(
    .WIDTH (bhpq_pkg::ENTRY_W),
    .DEPTH (bhpq_pkg::DEPTH)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign limit = (capacity_r > bhpq_pkg::CAP_W'(bhpq_pkg::DEPTH))
               ? bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH)
               : bhpq_pkg::CNT_W'(capacity_r);

  // Left child of the hole is 2*pos+1; the right one sits just after the left.
  assign left_idx  = {pos_r, 1'b1};
  assign right_idx = {1'b0, caddr_r} + bhpq_pkg::CNT_W'(1);

  // Child that the hole competes against. Ties between the children go left.
  always_comb begin
    if (state_r == bhpq_pkg::S_DN_PICK &&
        bhpq_pkg::prio_of(child_r) < bhpq_pkg::prio_of(mem_rdata)) begin
      cand      = mem_rdata;
      cand_addr = bhpq_pkg::ADDR_W'(right_idx);
    end else if (state_r == bhpq_pkg::S_DN_PICK) begin
      cand      = child_r;
      cand_addr = caddr_r;
    end else begin
      cand      = mem_rdata;
      cand_addr = caddr_r;
    end
  end

  // A key change goes ahead only when the new key moves strictly the right way.
  assign key_entry = {mem_rdata[bhpq_pkg::ENTRY_W-1:bhpq_pkg::PRIO_W], req_r};
  assign key_ok    = key_up_r ? (bhpq_pkg::prio_of(mem_rdata) < req_r)
                              : (bhpq_pkg::prio_of(mem_rdata) > req_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    hold_nxt      = hold_r;
    child_nxt     = child_r;
    pos_nxt       = pos_r;
    caddr_nxt     = caddr_r;
    req_nxt       = req_r;
    key_up_nxt    = key_up_r;
    status_nxt    = status_r;
    opay_nxt      = opay_r;
    opri_nxt      = opri_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r;
    mem_wdata     = hold_r;
    mem_raddr     = '0;

    case (state_r)
      bhpq_pkg::S_IDLE: begin
        if (start) begin
          status_nxt = bhpq_pkg::ST_OK;
          opay_nxt   = '0;
          opri_nxt   = '0;
          req_nxt    = in_priority_req;
          key_up_nxt = (in_command == bhpq_pkg::CMD_INC_KEY);
          case (in_command)
            bhpq_pkg::CMD_ENQUEUE: begin
              if (count_r >= limit) begin
                status_nxt    = bhpq_pkg::ST_FULL;
                out_valid_nxt = 1'b1;
              end else begin
                hold_nxt  = bhpq_pkg::make_entry(in_payload, in_priority_req);
                pos_nxt   = bhpq_pkg::ADDR_W'(count_r);
                count_nxt = count_r + bhpq_pkg::CNT_W'(1);
                state_nxt = bhpq_pkg::S_UP_RD;
              end
            end
            bhpq_pkg::CMD_DEQUEUE: begin
              if (count_r == '0) begin
                status_nxt    = bhpq_pkg::ST_EMPTY;
                out_valid_nxt = 1'b1;
              end else begin
                mem_raddr = '0;
                state_nxt = bhpq_pkg::S_DQ_ROOT;
              end
            end
            bhpq_pkg::CMD_INC_KEY,
            bhpq_pkg::CMD_DEC_KEY: begin
              if ({1'b0, in_slot} >= count_r) begin
                status_nxt    = bhpq_pkg::ST_BAD_SLOT;
                out_valid_nxt = 1'b1;
              end else begin
                mem_raddr = in_slot;
                pos_nxt   = in_slot;
                state_nxt = bhpq_pkg::S_KEY_RD;
              end
            end
            bhpq_pkg::CMD_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      bhpq_pkg::S_DQ_ROOT: begin
        // Root is on the read port; fetch the last entry to refill the root.
        opay_nxt  = mem_rdata[bhpq_pkg::ENTRY_W-1:bhpq_pkg::PRIO_W];
        opri_nxt  = mem_rdata[bhpq_pkg::PRIO_W-1:0];
        count_nxt = count_r - bhpq_pkg::CNT_W'(1);
        mem_raddr = bhpq_pkg::ADDR_W'(count_r - bhpq_pkg::CNT_W'(1));
        state_nxt = bhpq_pkg::S_DQ_LAST;
      end

      bhpq_pkg::S_DQ_LAST: begin
        hold_nxt  = mem_rdata;
        pos_nxt   = '0;
        state_nxt = bhpq_pkg::S_DN_L;
      end

      bhpq_pkg::S_KEY_RD: begin
        if (key_ok) begin
          hold_nxt  = key_entry;
          state_nxt = key_up_r ? bhpq_pkg::S_UP_RD : bhpq_pkg::S_DN_L;
        end else begin
          status_nxt    = bhpq_pkg::ST_UNCHANGED;
          out_valid_nxt = 1'b1;
          state_nxt     = bhpq_pkg::S_IDLE;
        end
      end

      bhpq_pkg::S_UP_RD: begin
        if (pos_r == '0) begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bhpq_pkg::S_IDLE;
        end else begin
          caddr_nxt = (pos_r - bhpq_pkg::ADDR_W'(1)) >> 1;
          mem_raddr = (pos_r - bhpq_pkg::ADDR_W'(1)) >> 1;
          state_nxt = bhpq_pkg::S_UP_CMP;
        end
      end

      bhpq_pkg::S_UP_CMP: begin
        mem_we = 1'b1;
        if (bhpq_pkg::prio_of(hold_r) <= bhpq_pkg::prio_of(mem_rdata)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = bhpq_pkg::S_IDLE;
        end else begin
          mem_wdata = mem_rdata;
          pos_nxt   = caddr_r;
          state_nxt = bhpq_pkg::S_UP_RD;
        end
      end

      bhpq_pkg::S_DN_L: begin
        if (left_idx >= count_r) begin
          // No child left: park the held entry, unless the queue just emptied.
          mem_we        = ({1'b0, pos_r} < count_r);
          out_valid_nxt = 1'b1;
          state_nxt     = bhpq_pkg::S_IDLE;
        end else begin
          caddr_nxt = bhpq_pkg::ADDR_W'(left_idx);
          mem_raddr = bhpq_pkg::ADDR_W'(left_idx);
          state_nxt = bhpq_pkg::S_DN_R;
        end
      end

      bhpq_pkg::S_DN_R,
      bhpq_pkg::S_DN_PICK: begin
        if (state_r == bhpq_pkg::S_DN_R && right_idx < count_r) begin
          child_nxt = mem_rdata;
          mem_raddr = bhpq_pkg::ADDR_W'(right_idx);
          state_nxt = bhpq_pkg::S_DN_PICK;
        end else begin
          mem_we = 1'b1;
          if (bhpq_pkg::prio_of(hold_r) >= bhpq_pkg::prio_of(cand)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = bhpq_pkg::S_IDLE;
          end else begin
            mem_wdata = cand;
            pos_nxt   = cand_addr;
            state_nxt = bhpq_pkg::S_DN_L;
          end
        end
      end

      default: begin
        state_nxt = bhpq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bhpq_pkg::S_IDLE;
      count_r     <= '0;
      capacity_r  <= bhpq_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_r   <= hold_nxt;
    child_r  <= child_nxt;
    pos_r    <= pos_nxt;
    caddr_r  <= caddr_nxt;
    req_r    <= req_nxt;
    key_up_r <= key_up_nxt;
    status_r <= status_nxt;
    opay_r   <= opay_nxt;
    opri_r   <= opri_nxt;
  end

  assign busy          = (state_r != bhpq_pkg::S_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_payload   = opay_r;
  assign out_priority  = $signed(opri_r);
  assign out_occupancy = count_r;
  assign out_is_empty  = (count_r == '0);

  // The entry count never grows past the store depth.
  `BHPQ_ASSERT(a_count_bound, clk, rst_n,
    count_r <= bhpq_pkg::CNT_W'(bhpq_pkg::DEPTH), "entry count above depth")
  // The heap RAM is written only inside the occupied region.
  `BHPQ_ASSERT(a_write_occupied, clk, rst_n,
    mem_we |-> ({1'b0, mem_waddr} < count_r), "heap write outside occupied slots")
  // A result strobe closes a request and leaves the block ready for the next.
  `BHPQ_ASSERT(a_strobe_idle, clk, rst_n,
    out_valid_r |-> !busy, "result strobe while busy")
  // A result strobe follows a taken request or a finished sift.
  `BHPQ_ASSERT(a_strobe_cause, clk, rst_n,
    out_valid_r |-> ($past(state_r) != bhpq_pkg::S_IDLE || $past(start)),
    "result strobe without a request")

endmodule

`default_nettype wire
